@@ sv/decimal_string_hash_bucket_top_defines.svh @@
// Assertion macros used by the top-level file to check its own logic.
`ifndef DECIMAL_STRING_HASH_BUCKET_TOP_DEFINES_SVH
`define DECIMAL_STRING_HASH_BUCKET_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSHB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSHB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dshb_pkg.sv @@
package dshb_pkg;

   localparam int KeyWidth    = 32;
   localparam int BucketBits  = 12;
   localparam int BucketWidth = 12;
   localparam int NodeWidth   = 11;
   localparam int NumDigits   = 10;
   localparam int MaxChars    = 11;
   localparam int RemBits     = 4;
   localparam int NodeSteps   = BucketWidth / RemBits;

   localparam logic [31:0] LenMult  = 32'h238F13AF;
   localparam logic [31:0] CharMask = 32'h7FFFFFFF;
   localparam logic [31:0] HashMult = 32'd1103515243;
   localparam logic [31:0] HashAdd  = 32'd12345;
   localparam logic [31:0] Recip10  = 32'hCCCCCCCD;
   localparam logic [7:0]  AsciiZero  = 8'h30;
   localparam logic [7:0]  AsciiMinus = 8'h2D;

   typedef logic [3:0] digit_type;
   typedef logic [3:0] count_type;
   typedef logic [NumDigits-1:0][3:0] digits_type;

   typedef struct packed {
      logic      valid;
      logic      neg;
      count_type nd;
   } dig_ctrl_type;

   // Shift applied to character i of the decimal text.
   function automatic logic [4:0] char_shift(input int i);
      return 5'((i * 5) % 24);
   endfunction

endpackage

@@ sv/decimal_string_hash_bucket_top.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_key (signed 32)
// rsp       out        rsp_valid / rsp_stall  rsp_bucket (12), rsp_node (11)
// csr       in         csr_valid / csr_ready  csr_data (11), the node count
//
// One key enters per cycle unless the pipeline is stalled; each result passes through the entry
// register, ten divide-by-ten digit stages, seven hashing stages and three remainder
// stages.
// Reset is synchronous and clears the stage valid bits and sets the node count to one.
// A stalled result freezes the whole pipeline, so the input is stalled in the same cycle.
// The configuration port is always ready.
`include "decimal_string_hash_bucket_top_defines.svh"

module decimal_string_hash_bucket_top import dshb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [KeyWidth-1:0] req_key,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [BucketWidth-1:0]     rsp_bucket,
   output logic [NodeWidth-1:0]       rsp_node,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [NodeWidth-1:0]       csr_data
);

   logic                 adv;
   logic [NodeWidth-1:0] node_count_ff;
   logic [NodeWidth-1:0] divisor;

   dig_ctrl_type dig_ctrl;
   digits_type   dig_digs;
   logic         nd_ok;

   logic        h1_valid_ff;
   logic [31:0] h1_terms_ff [MaxChars];
   logic [31:0] h1_base_ff;
   logic [31:0] h1_terms_in [MaxChars];
   logic [31:0] h1_base_in;
   count_type   len;

   logic        h2_valid_ff;
   logic [31:0] h2_sum_ff [3];
   logic        h3_valid_ff;
   logic [31:0] h3_v_ff;
   logic        m_valid_ff;
   logic [31:0] m_t_ff;
   logic        a_valid_ff;
   logic        a_neg_ff;
   logic [31:0] a_abs_ff;
   logic        r_valid_ff;
   logic        r_neg_ff;
   logic [16:0] r_mod_ff;
   logic [17:0] r_diff;
   logic [16:0] r_mod_in;
   logic        b_valid_ff;
   logic [BucketWidth-1:0] b_bucket_ff;
   logic [16:0] b_signed;
   logic [15:0] bucket_mask;
   logic [63:0] t_prod;

   // The whole pipeline moves unless a finished result is held back.
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NodeWidth'(1);
      end else if (csr_valid && csr_ready) begin
         node_count_ff <= csr_data;
      end
   end

   // A node count of zero behaves as one.
   assign divisor = (node_count_ff == '0) ? NodeWidth'(1) : node_count_ff;

   // Decimal conversion: entry register plus one stage per digit.
   dshb_digits u_digits (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_valid),
      .in_key   (req_key),
      .out_ctrl (dig_ctrl),
      .out_digs (dig_digs)
   );

   // A converted key always has between one and ten digits.
   assign nd_ok = (dig_ctrl.nd != '0) && (dig_ctrl.nd <= count_type'(NumDigits));

   // Character terms. Text position i holds the minus sign or digit L-1-i.
   assign len = count_type'(dig_ctrl.neg) + dig_ctrl.nd;

   always_comb begin
      logic [7:0] ch;
      count_type  idx;
      for (int i = 0; i < MaxChars; i++) begin
         idx = len - count_type'(1) - count_type'(i);
         if (count_type'(i) >= len) begin
            ch = 8'h00;
         end else if (dig_ctrl.neg && (i == 0)) begin
            ch = AsciiMinus;
         end else begin
            ch = AsciiZero + {4'h0, dig_digs[idx]};
         end
         h1_terms_in[i] = ({24'h0, ch} << char_shift(i)) & CharMask;
      end
      h1_base_in = LenMult * {28'h0, len};
   end

   // Remainder by 65537: since 2^16 is -1 modulo 65537, low half minus high half.
   assign r_diff   = {2'b00, a_abs_ff[15:0]} - {2'b00, a_abs_ff[31:16]};
   assign r_mod_in = r_diff[17] ? 17'(r_diff + 18'd65537) : r_diff[16:0];

   // Truncating remainder keeps the sign of the dividend.
   assign b_signed    = r_neg_ff ? (17'd0 - r_mod_ff) : r_mod_ff;
   assign bucket_mask = 16'((17'd1 << BucketBits) - 17'd1);
   assign t_prod      = {32'h0, h3_v_ff} * {32'h0, HashMult};

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff <= 1'b0;
         h2_valid_ff <= 1'b0;
         h3_valid_ff <= 1'b0;
         m_valid_ff  <= 1'b0;
         a_valid_ff  <= 1'b0;
         r_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
      end else if (adv) begin
         h1_valid_ff <= dig_ctrl.valid;
         h2_valid_ff <= h1_valid_ff;
         h3_valid_ff <= h2_valid_ff;
         m_valid_ff  <= h3_valid_ff;
         a_valid_ff  <= m_valid_ff;
         r_valid_ff  <= a_valid_ff;
         b_valid_ff  <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h1_terms_ff  <= h1_terms_in;
         h1_base_ff   <= h1_base_in;
         h2_sum_ff[0] <= h1_base_ff + h1_terms_ff[0] + h1_terms_ff[1] + h1_terms_ff[2];
         h2_sum_ff[1] <= h1_terms_ff[3] + h1_terms_ff[4] + h1_terms_ff[5] + h1_terms_ff[6];
         h2_sum_ff[2] <= h1_terms_ff[7] + h1_terms_ff[8] + h1_terms_ff[9]
                         + h1_terms_ff[10];
         h3_v_ff      <= h2_sum_ff[0] + h2_sum_ff[1] + h2_sum_ff[2];
         m_t_ff       <= t_prod[31:0] + HashAdd;
         a_neg_ff     <= m_t_ff[31];
         a_abs_ff     <= m_t_ff[31] ? (32'd0 - m_t_ff) : m_t_ff;
         r_neg_ff     <= a_neg_ff;
         r_mod_ff     <= r_mod_in;
         b_bucket_ff  <= BucketWidth'(b_signed[15:0] & bucket_mask);
      end
   end

   // Bucket modulo node count, then plus one.
   dshb_node_mod u_node_mod (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (b_valid_ff),
      .in_bucket  (b_bucket_ff),
      .divisor    (divisor),
      .out_valid  (rsp_valid),
      .out_bucket (rsp_bucket),
      .out_node   (rsp_node)
   );

   `DSHB_ASSERT_NOW(a_node_nonzero, clock, reset, rsp_valid, rsp_node != '0, "node is zero")
   `DSHB_ASSERT_NOW(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall, "stall lost")
   `DSHB_ASSERT_NOW(a_digit_count, clock, reset, dig_ctrl.valid, nd_ok, "bad digit count")

endmodule

@@ sv/dshb_digits.sv @@
module dshb_digits import dshb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic signed [KeyWidth-1:0] in_key,
   output dig_ctrl_type               out_ctrl,
   output digits_type                 out_digs
);

   logic                ent_valid_ff;
   logic                ent_neg_ff;
   logic [KeyWidth-1:0] ent_mag_ff;

   logic                st_valid_ff [NumDigits];
   logic                st_neg_ff   [NumDigits];
   logic [KeyWidth-1:0] st_mag_ff   [NumDigits];
   count_type           st_nd_ff    [NumDigits];
   digits_type          st_digs_ff  [NumDigits];

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else if (en) begin
         ent_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ent_neg_ff <= in_key[KeyWidth-1];
         ent_mag_ff <= in_key[KeyWidth-1] ? (KeyWidth'(0) - KeyWidth'($unsigned(in_key)))
                                          : KeyWidth'($unsigned(in_key));
      end
   end

   // One decimal digit per stage, least significant first.
   for (genvar k = 0; k < NumDigits; k++) begin : g_stage
      logic                  src_valid;
      logic                  src_neg;
      logic [KeyWidth-1:0]   src_mag;
      count_type             src_nd;
      digits_type            src_digs;
      digits_type            digs_in;
      logic [2*KeyWidth-1:0] prod;
      logic [KeyWidth-1:0]   quo;
      logic [KeyWidth-1:0]   rem;
      logic                  emit;

      if (k == 0) begin : g_first
         assign src_valid = ent_valid_ff;
         assign src_neg   = ent_neg_ff;
         assign src_mag   = ent_mag_ff;
         assign src_nd    = '0;
         assign src_digs  = '0;
      end else begin : g_next
         assign src_valid = st_valid_ff[k-1];
         assign src_neg   = st_neg_ff[k-1];
         assign src_mag   = st_mag_ff[k-1];
         assign src_nd    = st_nd_ff[k-1];
         assign src_digs  = st_digs_ff[k-1];
      end

      // Exact divide by ten for every 32-bit value.
      assign prod = {{KeyWidth{1'b0}}, src_mag} * {{KeyWidth{1'b0}}, Recip10};
      assign quo  = KeyWidth'(prod >> 35);
      assign rem  = src_mag - ((quo << 3) + (quo << 1));
      assign emit = (k == 0) || (src_mag != '0);

      always_comb begin
         digs_in    = src_digs;
         digs_in[k] = rem[3:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[k] <= 1'b0;
         end else if (en) begin
            st_valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_neg_ff[k]  <= src_neg;
            st_mag_ff[k]  <= quo;
            st_nd_ff[k]   <= emit ? (src_nd + count_type'(1)) : src_nd;
            st_digs_ff[k] <= digs_in;
         end
      end
   end

   assign out_ctrl = '{valid: st_valid_ff[NumDigits-1],
                       neg:   st_neg_ff[NumDigits-1],
                       nd:    st_nd_ff[NumDigits-1]};
   assign out_digs = st_digs_ff[NumDigits-1];

endmodule

@@ sv/dshb_node_mod.sv @@
module dshb_node_mod import dshb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [BucketWidth-1:0] in_bucket,
   input  logic [NodeWidth-1:0]   divisor,
   output logic                   out_valid,
   output logic [BucketWidth-1:0] out_bucket,
   output logic [NodeWidth-1:0]   out_node
);

   logic                   nv_ff [NodeSteps];
   logic [BucketWidth-1:0] nb_ff [NodeSteps];
   logic [BucketWidth-1:0] nr_ff [NodeSteps];

   // Restoring remainder, RemBits quotient bits per stage.
   for (genvar s = 0; s < NodeSteps; s++) begin : g_step
      logic                   src_valid;
      logic [BucketWidth-1:0] src_bucket;
      logic [BucketWidth-1:0] src_rem;
      logic [BucketWidth-1:0] rem;

      if (s == 0) begin : g_first
         assign src_valid  = in_valid;
         assign src_bucket = in_bucket;
         assign src_rem    = '0;
      end else begin : g_next
         assign src_valid  = nv_ff[s-1];
         assign src_bucket = nb_ff[s-1];
         assign src_rem    = nr_ff[s-1];
      end

      always_comb begin
         rem = src_rem;
         for (int j = 0; j < RemBits; j++) begin
            rem = {rem[BucketWidth-2:0], src_bucket[BucketWidth-1-(s*RemBits)-j]};
            if (rem >= {1'b0, divisor}) begin
               rem = rem - {1'b0, divisor};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nv_ff[s] <= 1'b0;
         end else if (en) begin
            nv_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nb_ff[s] <= src_bucket;
            nr_ff[s] <= rem;
         end
      end
   end

   assign out_valid  = nv_ff[NodeSteps-1];
   assign out_bucket = nb_ff[NodeSteps-1];
   assign out_node   = NodeWidth'(nr_ff[NodeSteps-1]) + NodeWidth'(1);

endmodule
